@@ src/dtd_pkg.sv @@
// Shared types, constants and calendar helpers for the date to day count block.
// No dependencies; used by dtd_pipe_ctl, the top level and the testbench.
`timescale 1ns / 1ps

package dtd_pkg;

	localparam int NUM_STAGES = 5;

	localparam logic [13:0] EPOCH_YEAR    = 14'd1970;
	localparam logic [13:0] MAX_YEAR      = 14'd9999;
	localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
	// leap years in 1..1969
	localparam logic [11:0] EPOCH_LEAPS   = 12'd477;
	// floor(x * 2621 / 2^16) is x / 25 or one below, for x < 4096
	localparam logic [11:0] RECIP_25      = 12'd2621;
	localparam logic [11:0] CENTURY_QTR   = 12'd25;
	// floor(x * 73 / 2^9) is x / 7 or one below, for x < 512
	localparam logic [6:0]  RECIP_7       = 7'd73;
	localparam logic [8:0]  DAYS_PER_WEEK = 9'd7;

	localparam logic [3:0] JANUARY  = 4'd1;
	localparam logic [3:0] FEBRUARY = 4'd2;
	localparam logic [3:0] DECEMBER = 4'd12;

	localparam logic [2:0] SUNDAY   = 3'd0;
	localparam logic [2:0] MONDAY   = 3'd1;
	localparam logic [2:0] FRIDAY   = 3'd5;
	localparam logic [2:0] SATURDAY = 3'd6;
	localparam logic [2:0] MOD7_TOP = 3'd7;

	typedef struct packed {
		logic [NUM_STAGES-1:0] load;
		logic [NUM_STAGES-1:0] valid;
	} pipe_ctl_t;

	// days before the first of the month, non-leap year
	function automatic logic [8:0] month_offset(input logic [3:0] m);
		logic [8:0] v;
		case (m)
			4'd2:    v = 9'd31;
			4'd3:    v = 9'd59;
			4'd4:    v = 9'd90;
			4'd5:    v = 9'd120;
			4'd6:    v = 9'd151;
			4'd7:    v = 9'd181;
			4'd8:    v = 9'd212;
			4'd9:    v = 9'd243;
			4'd10:   v = 9'd273;
			4'd11:   v = 9'd304;
			4'd12:   v = 9'd334;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

	// month length, non-leap year
	function automatic logic [4:0] month_length(input logic [3:0] m);
		logic [4:0] v;
		case (m)
			4'd2:    v = 5'd28;
			4'd4:    v = 5'd30;
			4'd6:    v = 5'd30;
			4'd9:    v = 5'd30;
			4'd11:   v = 5'd30;
			default: v = 5'd31;
		endcase
		return v;
	endfunction

	// x mod 7 by folding octal digits (8 = 1 mod 7)
	function automatic logic [2:0] mod7_22(input logic [21:0] x);
		logic [23:0] w;
		logic [5:0]  s;
		logic [3:0]  t;
		logic [2:0]  u;
		w = {2'b00, x};
		s = 6'd0;
		for (int i = 0; i < 8; i++) begin
			s = s + {3'd0, w[3*i +: 3]};
		end
		t = {1'b0, s[5:3]} + {1'b0, s[2:0]};
		u = {2'b00, t[3]} + t[2:0];
		return (u == MOD7_TOP) ? 3'd0 : u;
	endfunction

endpackage

@@ src/dtd_pipe_ctl.sv @@
// Valid/ready control for the date pipeline: per-stage valid bits, load enables.
// Depends on dtd_pkg.
`timescale 1ns / 1ps

module dtd_pipe_ctl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	output logic                up_ready,
	input  logic                down_ready,
	output dtd_pkg::pipe_ctl_t  ctl
);

	localparam int N = dtd_pkg::NUM_STAGES;

	logic [N-1:0] valid_q;
	logic [N:0]   rdy;

	// a stage loads when it is empty or its word moves on; bubbles collapse
	always_comb begin
		rdy[N] = down_ready;
		for (int i = N - 1; i >= 0; i--) begin
			rdy[i] = !valid_q[i] || rdy[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int i = 0; i < N; i++) begin
				if (rdy[i]) begin
					valid_q[i] <= (i == 0) ? up_valid : valid_q[(i == 0) ? 0 : i - 1];
				end
			end
		end
	end

	assign up_ready  = rdy[0];
	assign ctl.load  = rdy[N-1:0];
	assign ctl.valid = valid_q;

endmodule

@@ src/date_to_day_count_weekday.sv @@
// Top level: Gregorian date to epoch day count, weekday, week and next workday.
// Depends on dtd_pkg and dtd_pipe_ctl.
`timescale 1ns / 1ps
//
// Input channel date_valid/date_ready carries one date word (year, month,
// day_of_month). Output channel result_valid/result_ready carries one result
// word per date, in order.
// The pipeline has five register stages: range fixups and the /25 reciprocal
// products, leap and day-of-year, the epoch day count product, the mod 7
// folds and week number, the final workday step. result_valid is the valid
// bit of the final stage; throughput is one word per cycle whenever
// result_ready is high.
// Each stage has its own valid bit and loads when empty or when its word
// moves on, so an empty stage keeps taking words while the result waits.
// date_ready depends combinationally on result_ready through the stages.
// Reset clears all valid bits; no result is pending after reset.
// Years before 1970 give too_early = 1 and all other fields zero.

module date_to_day_count_weekday (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        date_valid,
	output logic        date_ready,
	input  logic [13:0] year,
	input  logic [3:0]  month,
	input  logic [4:0]  day_of_month,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        too_early,
	output logic [21:0] days_since_epoch,
	output logic [2:0]  weekday,
	output logic        workday,
	output logic [5:0]  week_number,
	output logic [13:0] next_year,
	output logic [3:0]  next_month,
	output logic [4:0]  next_mday
);

	dtd_pkg::pipe_ctl_t ctl;

	dtd_pipe_ctl u_ctl (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (date_valid),
		.up_ready   (date_ready),
		.down_ready (result_ready),
		.ctl        (ctl)
	);

	// ---------------- stage 1: fixups, reciprocal products
	logic [13:0] y_c;
	logic [3:0]  m_c;
	logic [4:0]  d_c;
	logic [13:0] ym1_c;

	always_comb begin
		y_c   = (year > dtd_pkg::MAX_YEAR) ? dtd_pkg::MAX_YEAR : year;
		m_c   = (month < dtd_pkg::JANUARY || month > dtd_pkg::DECEMBER) ?
			dtd_pkg::JANUARY : month;
		d_c   = (day_of_month == 5'd0) ? 5'd1 : day_of_month;
		ym1_c = y_c - 14'd1;
	end

	logic        te_s1;
	logic [13:0] y_s1;
	logic [3:0]  m_s1;
	logic [4:0]  d_s1;
	logic [11:0] nq_s1;
	logic [23:0] py_s1;
	logic [23:0] pn_s1;

	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			te_s1 <= year < dtd_pkg::EPOCH_YEAR;
			y_s1  <= y_c;
			m_s1  <= m_c;
			d_s1  <= d_c;
			nq_s1 <= ym1_c[13:2];
			py_s1 <= {12'd0, y_c[13:2]} * {12'd0, dtd_pkg::RECIP_25};
			pn_s1 <= {12'd0, ym1_c[13:2]} * {12'd0, dtd_pkg::RECIP_25};
		end
	end

	// ---------------- stage 2: /25 correction, leap, day of year, month length, leap count
	logic [11:0] qy_raw, qn_raw, ry_raw, rn_raw, qy_c, qn_c, ry_c;
	logic        leap_c;
	logic [8:0]  yd_c;
	logic [4:0]  len_c;
	logic [11:0] lc_c;

	always_comb begin
		qy_raw = {4'd0, py_s1[23:16]};
		qn_raw = {4'd0, pn_s1[23:16]};
		ry_raw = y_s1[13:2] - qy_raw * dtd_pkg::CENTURY_QTR;
		rn_raw = nq_s1 - qn_raw * dtd_pkg::CENTURY_QTR;
		qy_c   = (ry_raw >= dtd_pkg::CENTURY_QTR) ? qy_raw + 12'd1 : qy_raw;
		ry_c   = (ry_raw >= dtd_pkg::CENTURY_QTR) ? ry_raw - dtd_pkg::CENTURY_QTR : ry_raw;
		qn_c   = (rn_raw >= dtd_pkg::CENTURY_QTR) ? qn_raw + 12'd1 : qn_raw;
		// divisible by 4, and not by 100 unless by 400
		leap_c = (y_s1[1:0] == 2'd0) && ((ry_c != 12'd0) || (qy_c[1:0] == 2'd0));
		yd_c   = dtd_pkg::month_offset(m_s1) + {4'd0, d_s1} +
			{8'd0, (m_s1 > dtd_pkg::FEBRUARY) && leap_c};
		len_c  = dtd_pkg::month_length(m_s1) +
			{4'd0, (m_s1 == dtd_pkg::FEBRUARY) && leap_c};
		lc_c   = nq_s1 - qn_c + {2'd0, qn_c[11:2]} - dtd_pkg::EPOCH_LEAPS;
	end

	logic        te_s2;
	logic [13:0] y_s2;
	logic [3:0]  m_s2;
	logic [4:0]  d_s2;
	logic        leap_s2;
	logic [4:0]  len_s2;
	logic [8:0]  yd_s2;
	logic [10:0] lc_s2;

	always_ff @(posedge clk) begin
		if (ctl.load[1]) begin
			te_s2   <= te_s1;
			y_s2    <= y_s1;
			m_s2    <= m_s1;
			d_s2    <= d_s1;
			leap_s2 <= leap_c;
			len_s2  <= len_c;
			yd_s2   <= yd_c;
			lc_s2   <= lc_c[10:0];
		end
	end

	// ---------------- stage 3: day count, first day step, week product
	logic [12:0] yoff_c;
	logic [21:0] days_c;
	logic [13:0] ny1_c;
	logic [3:0]  nm1_c;
	logic [4:0]  nd1_c;
	logic [5:0]  adj_c;
	logic [8:0]  ydm1_c;

	always_comb begin
		yoff_c = 13'(y_s2 - dtd_pkg::EPOCH_YEAR);
		days_c = {9'd0, yoff_c} * {13'd0, dtd_pkg::DAYS_PER_YEAR} + {11'd0, lc_s2} +
			{13'd0, yd_s2} - 22'd1;
		ydm1_c = yd_s2 - 9'd1;
		// adj = weekday offset of the stepped date, mod 7, plus the epoch weekday
		if (d_s2 < len_s2) begin
			ny1_c = y_s2;
			nm1_c = m_s2;
			nd1_c = d_s2 + 5'd1;
			adj_c = 6'd12;
		end else begin
			nd1_c = 5'd1;
			adj_c = {1'b0, len_s2} + 6'd12 - {1'b0, d_s2};
			if (m_s2 >= dtd_pkg::DECEMBER) begin
				nm1_c = dtd_pkg::JANUARY;
				ny1_c = y_s2 + 14'd1;
			end else begin
				nm1_c = m_s2 + 4'd1;
				ny1_c = y_s2;
			end
		end
	end

	logic        te_s3;
	logic [21:0] days_s3;
	logic [5:0]  adj_s3;
	logic [13:0] ny1_s3;
	logic [3:0]  nm1_s3;
	logic [4:0]  nd1_s3;
	logic        leap_s3;
	logic [8:0]  ydm1_s3;
	logic [15:0] wp_s3;

	always_ff @(posedge clk) begin
		if (ctl.load[2]) begin
			te_s3   <= te_s2;
			days_s3 <= days_c;
			adj_s3  <= adj_c;
			ny1_s3  <= ny1_c;
			nm1_s3  <= nm1_c;
			nd1_s3  <= nd1_c;
			leap_s3 <= leap_s2;
			ydm1_s3 <= ydm1_c;
			wp_s3   <= {7'd0, ydm1_c} * {9'd0, dtd_pkg::RECIP_7};
		end
	end

	// ---------------- stage 4: weekdays, week number, stepped month length
	logic [2:0] wd_c, w1_c;
	logic [8:0] wq_c, wr_c;
	logic [5:0] week_c;
	logic [4:0] len1_c;

	always_comb begin
		wd_c   = dtd_pkg::mod7_22(days_s3 + 22'd4);
		w1_c   = dtd_pkg::mod7_22(days_s3 + {16'd0, adj_s3});
		wq_c   = {2'd0, wp_s3[15:9]};
		wr_c   = ydm1_s3 - wq_c * dtd_pkg::DAYS_PER_WEEK;
		week_c = wq_c[5:0] + 6'd1 + {5'd0, wr_c >= dtd_pkg::DAYS_PER_WEEK};
		len1_c = dtd_pkg::month_length(nm1_s3) +
			{4'd0, (nm1_s3 == dtd_pkg::FEBRUARY) && leap_s3};
	end

	logic        te_s4;
	logic [21:0] days_s4;
	logic [2:0]  wd_s4;
	logic [2:0]  w1_s4;
	logic [5:0]  week_s4;
	logic [13:0] ny1_s4;
	logic [3:0]  nm1_s4;
	logic [4:0]  nd1_s4;
	logic [4:0]  len1_s4;

	always_ff @(posedge clk) begin
		if (ctl.load[3]) begin
			te_s4   <= te_s3;
			days_s4 <= days_s3;
			wd_s4   <= wd_c;
			w1_s4   <= w1_c;
			week_s4 <= week_c;
			ny1_s4  <= ny1_s3;
			nm1_s4  <= nm1_s3;
			nd1_s4  <= nd1_s3;
			len1_s4 <= len1_c;
		end
	end

	// ---------------- stage 5: skip the weekend, zero fields when too early
	logic [1:0]  skip_c;
	logic [5:0]  sum_c;
	logic [13:0] ny_c;
	logic [3:0]  nm_c;
	logic [4:0]  nd_c;

	always_comb begin
		case (w1_s4)
			dtd_pkg::SATURDAY: skip_c = 2'd2;
			dtd_pkg::SUNDAY:   skip_c = 2'd1;
			default:           skip_c = 2'd0;
		endcase
		// stepped date is valid, so at most one more month rollover
		sum_c = {1'b0, nd1_s4} + {4'd0, skip_c};
		if (sum_c <= {1'b0, len1_s4}) begin
			ny_c = ny1_s4;
			nm_c = nm1_s4;
			nd_c = sum_c[4:0];
		end else begin
			nd_c = 5'(sum_c - {1'b0, len1_s4});
			if (nm1_s4 >= dtd_pkg::DECEMBER) begin
				nm_c = dtd_pkg::JANUARY;
				ny_c = ny1_s4 + 14'd1;
			end else begin
				nm_c = nm1_s4 + 4'd1;
				ny_c = ny1_s4;
			end
		end
	end

	logic        te_s5;
	logic [21:0] days_s5;
	logic [2:0]  wd_s5;
	logic        work_s5;
	logic [5:0]  week_s5;
	logic [13:0] ny_s5;
	logic [3:0]  nm_s5;
	logic [4:0]  nd_s5;

	always_ff @(posedge clk) begin
		if (ctl.load[4]) begin
			te_s5   <= te_s4;
			days_s5 <= te_s4 ? 22'd0 : days_s4;
			wd_s5   <= te_s4 ? 3'd0 : wd_s4;
			work_s5 <= !te_s4 && (wd_s4 >= dtd_pkg::MONDAY) && (wd_s4 <= dtd_pkg::FRIDAY);
			week_s5 <= te_s4 ? 6'd0 : week_s4;
			ny_s5   <= te_s4 ? 14'd0 : ny_c;
			nm_s5   <= te_s4 ? 4'd0 : nm_c;
			nd_s5   <= te_s4 ? 5'd0 : nd_c;
		end
	end

	assign result_valid     = ctl.valid[4];
	assign too_early        = te_s5;
	assign days_since_epoch = days_s5;
	assign weekday          = wd_s5;
	assign workday          = work_s5;
	assign week_number      = week_s5;
	assign next_year        = ny_s5;
	assign next_month       = nm_s5;
	assign next_mday        = nd_s5;

endmodule

@@ src/dtd_checker.sv @@
// Port-level checks for date_to_day_count_weekday, attached by bind.
// Depends on the top level's ports only.
`timescale 1ns / 1ps

module dtd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_ready,
	input logic        too_early,
	input logic [21:0] days_since_epoch,
	input logic [2:0]  weekday,
	input logic        workday,
	input logic [5:0]  week_number,
	input logic [13:0] next_year,
	input logic [3:0]  next_month,
	input logic [4:0]  next_mday
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result word dropped while stalled");

	a_early_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && too_early |-> days_since_epoch == 22'd0 && weekday == 3'd0 &&
			!workday && week_number == 6'd0 && next_year == 14'd0 &&
			next_month == 4'd0 && next_mday == 5'd0)
		else $error("too_early word has nonzero fields");

	a_workday: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !too_early |-> weekday <= 3'd6 &&
			workday == (weekday >= 3'd1 && weekday <= 3'd5))
		else $error("weekday and workday disagree");

	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !too_early |-> week_number >= 6'd1 && week_number <= 6'd53 &&
			next_month >= 4'd1 && next_month <= 4'd12 && next_mday >= 5'd1 &&
			next_year >= 14'd1970)
		else $error("result field out of range");

endmodule

bind date_to_day_count_weekday dtd_checker u_dtd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.result_valid     (result_valid),
	.result_ready     (result_ready),
	.too_early        (too_early),
	.days_since_epoch (days_since_epoch),
	.weekday          (weekday),
	.workday          (workday),
	.week_number      (week_number),
	.next_year        (next_year),
	.next_month       (next_month),
	.next_mday        (next_mday)
);

@@ dv/tb_date_to_day_count_weekday.sv @@
// Testbench for date_to_day_count_weekday: drives date words, predicts each result word
// and checks it field by field. Depends on dtd_pkg and the block under test.
`timescale 1ns / 1ps

module tb_date_to_day_count_weekday;

	localparam int unsigned EPOCH_WEEKDAY = 4;	// 1 Jan 1970 was a Thursday
	localparam int          ITEMS_PER_PHASE = 300;
	localparam int          CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic        too_early;
		logic [21:0] days_since_epoch;
		logic [2:0]  weekday;
		logic        workday;
		logic [5:0]  week_number;
		logic [13:0] next_year;
		logic [3:0]  next_month;
		logic [4:0]  next_mday;
	} cal_result_t;

	class calendar_scoreboard;
		cal_result_t expected_q[$];
		int          errors = 0;

		function bit leap_year(int unsigned y);
			return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
		endfunction

		function int unsigned month_days(int unsigned y, int unsigned m);
			case (m)
				dtd_pkg::FEBRUARY: return leap_year(y) ? 29 : 28;
				4, 6, 9, 11:       return 30;
				default:           return 31;
			endcase
		endfunction

		function int unsigned days_before_month(int unsigned y, int unsigned m);
			int unsigned acc;
			acc = 0;
			for (int unsigned k = dtd_pkg::JANUARY; k < m; k++) begin
				acc += month_days(y, k);
			end
			return acc;
		endfunction

		function int unsigned leaps_upto(int unsigned n);
			return n / 4 - n / 100 + n / 400;
		endfunction

		function int unsigned day_count(int unsigned y, int unsigned m, int unsigned d);
			return (y - dtd_pkg::EPOCH_YEAR) * 365 + leaps_upto(y - 1)
				- leaps_upto(dtd_pkg::EPOCH_YEAR - 1) + days_before_month(y, m) + d - 1;
		endfunction

		function bit mon_to_fri(int unsigned wd);
			return wd >= dtd_pkg::MONDAY && wd <= dtd_pkg::FRIDAY;
		endfunction

		// calendar-correct next date; an oversized day rolls to the 1st of next month
		function void step_date(inout int unsigned y, inout int unsigned m,
				inout int unsigned d);
			if (d >= month_days(y, m)) begin
				d = 1;
				if (m >= dtd_pkg::DECEMBER) begin
					m = dtd_pkg::JANUARY;
					y++;
				end else begin
					m++;
				end
			end else begin
				d++;
			end
		endfunction

		function cal_result_t predict_calendar(int unsigned y, int unsigned m, int unsigned d);
			cal_result_t r;
			int unsigned days, wd, ny, nm, nd;
			r = '0;
			if (y < dtd_pkg::EPOCH_YEAR) begin
				r.too_early = 1'b1;
				return r;
			end
			if (y > dtd_pkg::MAX_YEAR) y = dtd_pkg::MAX_YEAR;
			if (m < dtd_pkg::JANUARY || m > dtd_pkg::DECEMBER) m = dtd_pkg::JANUARY;
			if (d == 0) d = 1;
			days = day_count(y, m, d);
			wd = (EPOCH_WEEKDAY + days) % 7;
			ny = y;
			nm = m;
			nd = d;
			step_date(ny, nm, nd);
			for (int i = 0; i < 7; i++) begin
				if (mon_to_fri((EPOCH_WEEKDAY + day_count(ny, nm, nd)) % 7)) break;
				step_date(ny, nm, nd);
			end
			r.days_since_epoch = 22'(days);
			r.weekday = 3'(wd);
			r.workday = mon_to_fri(wd);
			r.week_number = 6'(1 + (days_before_month(y, m) + d - 1) / 7);
			r.next_year = 14'(ny);
			r.next_month = 4'(nm);
			r.next_mday = 5'(nd);
			return r;
		endfunction

		function void note_date(int unsigned y, int unsigned m, int unsigned d);
			expected_q.push_back(predict_calendar(y, m, d));
		endfunction

		function void check_field(string name, int unsigned exp_v, int unsigned got_v);
			if (exp_v != got_v) begin
				$error("%s: expected %0d, got %0d", name, exp_v, got_v);
				errors++;
			end
		endfunction

		function void check_result(cal_result_t got);
			cal_result_t exp_r;
			if (expected_q.size() == 0) begin
				$error("result word with no date pending");
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			check_field("too_early", exp_r.too_early, got.too_early);
			check_field("days_since_epoch", exp_r.days_since_epoch, got.days_since_epoch);
			check_field("weekday", exp_r.weekday, got.weekday);
			check_field("workday", exp_r.workday, got.workday);
			check_field("week_number", exp_r.week_number, got.week_number);
			check_field("next_year", exp_r.next_year, got.next_year);
			check_field("next_month", exp_r.next_month, got.next_month);
			check_field("next_mday", exp_r.next_mday, got.next_mday);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        date_valid;
	logic        date_ready;
	logic [13:0] year;
	logic [3:0]  month;
	logic [4:0]  day_of_month;
	logic        result_valid;
	logic        result_ready;
	logic        too_early;
	logic [21:0] days_since_epoch;
	logic [2:0]  weekday;
	logic        workday;
	logic [5:0]  week_number;
	logic [13:0] next_year;
	logic [3:0]  next_month;
	logic [4:0]  next_mday;

	calendar_scoreboard sb = new();
	int send_idle_pct = 35;
	int recv_idle_pct = 81;
	int cycles = 0;

	date_to_day_count_weekday dut (
		.clk(clk),
		.arst_n(arst_n),
		.date_valid(date_valid),
		.date_ready(date_ready),
		.year(year),
		.month(month),
		.day_of_month(day_of_month),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.too_early(too_early),
		.days_since_epoch(days_since_epoch),
		.weekday(weekday),
		.workday(workday),
		.week_number(week_number),
		.next_year(next_year),
		.next_month(next_month),
		.next_mday(next_mday)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[date_to_day_count_weekday] ERROR");
			$finish;
		end
	end

	// both channels sampled on pre-edge values
	always @(posedge clk) begin
		cal_result_t got;
		if (arst_n) begin
			if (date_valid && date_ready) sb.note_date(year, month, day_of_month);
			if (result_valid && result_ready) begin
				got.too_early = too_early;
				got.days_since_epoch = days_since_epoch;
				got.weekday = weekday;
				got.workday = workday;
				got.week_number = week_number;
				got.next_year = next_year;
				got.next_month = next_month;
				got.next_mday = next_mday;
				sb.check_result(got);
			end
		end
	end

	// returns at the edge where the word is taken
	task send_date(input int unsigned y, input int unsigned m, input int unsigned d);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			date_valid <= 1'b0;
			@(posedge clk);
		end
		date_valid <= 1'b1;
		year <= 14'(y);
		month <= 4'(m);
		day_of_month <= 5'(d);
		do @(posedge clk); while (!date_ready);
	endtask

	task send_random_date();
		int unsigned y, m, d, len, pick;
		pick = $urandom_range(0, 99);
		if (pick < 8) y = $urandom_range(0, 1969);
		else if (pick < 13) y = $urandom_range(10000, 16383);
		else y = $urandom_range(1970, 9999);
		if ($urandom_range(0, 9) == 0) m = $urandom_range(0, 15);
		else m = $urandom_range(1, 12);
		len = sb.month_days(y > dtd_pkg::MAX_YEAR ? dtd_pkg::MAX_YEAR : y, m);
		pick = $urandom_range(0, 99);
		// month ends exercise the next-workday rollover
		if (pick < 10) d = $urandom_range(0, 31);
		else if (pick < 35) d = $urandom_range(len - 2, len);
		else d = $urandom_range(1, len);
		send_date(y, m, d);
	endtask

	task wait_drained();
		date_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task run_phase(input int n, input int s_pct, input int r_pct);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		repeat (n) send_random_date();
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		date_valid <= 1'b0;
		year <= '0;
		month <= '0;
		day_of_month <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_date(0, 1, 1);
		send_date(1969, 12, 31);
		send_date(1970, 1, 1);
		send_date(1970, 1, 2);		// Friday: skips the weekend
		send_date(1970, 1, 3);
		send_date(1970, 1, 4);
		send_date(9999, 12, 31);	// next workday lands in year 10000
		send_date(16383, 15, 31);
		send_date(12000, 6, 15);
		send_date(10922, 11, 10);
		send_date(5461, 10, 21);
		send_date(2000, 2, 29);
		send_date(2000, 2, 31);		// day past month end
		send_date(2100, 2, 28);
		send_date(2100, 2, 29);
		send_date(2024, 12, 31);
		send_date(2023, 12, 29);
		send_date(2024, 0, 10);
		send_date(2024, 13, 5);
		send_date(2024, 15, 0);
		send_date(2024, 5, 0);
		send_date(1999, 4, 31);
		send_date(2021, 12, 31);
		send_date(8191, 7, 20);
		send_date(4096, 8, 16);
		wait_drained();

		run_phase(ITEMS_PER_PHASE, 35, 81);
		run_phase(ITEMS_PER_PHASE, 81, 35);
		run_phase(ITEMS_PER_PHASE, 0, 0);

		repeat (dtd_pkg::NUM_STAGES + 10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("[date_to_day_count_weekday] OK");
		end else begin
			$display("[date_to_day_count_weekday] ERROR");
		end
		$finish;
	end

endmodule
